// File: hw/rtl/ckvt_pkg.sv
// Package for the clustered key-value table: sizes, codes and the types that
// pass between the controller and the datapath. No dependencies.
`default_nettype none

package ckvt_pkg;

  // Table geometry. CHUNK_SLOTS and HOLE_SLOTS are powers of two.
  localparam int CHUNK_SLOTS  = 64;
  localparam int NUM_CLUSTERS = 16;
  localparam int HOLE_SLOTS   = 32;

  localparam int CLUSTER_SPAN = 4 * CHUNK_SLOTS;
  localparam int CHUNK_W      = $clog2(CHUNK_SLOTS);
  localparam int SPAN_W       = CHUNK_W + 2;
  localparam int CL_W         = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int SLOT_W       = CL_W + SPAN_W;
  localparam int HOLE_W       = $clog2(HOLE_SLOTS);
  localparam int HCNT_W       = HOLE_W + 1;
  localparam int FILL_W       = CHUNK_W + 1;
  localparam int IDX_W        = ((SPAN_W > HOLE_W) ? SPAN_W : HOLE_W) + 1;

  // Field widths of the words on the channels.
  localparam int KIND_W     = 2;
  localparam int DATA_W     = 32;
  localparam int PICK_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 12;
  localparam int OFFSET_W   = 20;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(2048);
  localparam logic [0:0]          REG_KEY_OFFSET = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CHECK,
    OP_FILL,
    OP_SCAN,
    OP_HIT,
    OP_FOUND,
    OP_HOLE,
    OP_WRITE,
    OP_APPEND
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic  out_range;
    logic  fill_done;
    logic  scan_hit;
    logic  scan_miss;
    logic  hole_hit;
    logic  hole_miss;
    kind_e kind;
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/ckvt_if.sv
// Channel interfaces of the clustered key-value table: request and response.
// Depends on ckvt_pkg.
`default_nettype none

interface ckvt_req_if;
  import ckvt_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DATA_W-1:0]   key;
  logic [DATA_W-1:0]   value;
  logic [PICK_W-1:0]   chunk_pick;
  modport source (output valid, kind, key, value, chunk_pick, input ready);
  modport sink   (input valid, kind, key, value, chunk_pick, output ready);
endinterface

interface ckvt_rsp_if;
  import ckvt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [DATA_W-1:0]     found_value;
  logic [SLOT_OUT_W-1:0] slot_index;
  modport source (output valid, status, found_value, slot_index, input ready);
  modport sink   (input valid, status, found_value, slot_index, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ckvt_dpath.sv
// Datapath of the clustered key-value table: slot, fill and hole memories,
// scan counters and result registers. Depends on ckvt_pkg.
`default_nettype none

module ckvt_dpath (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  ckvt_pkg::cmd_t                cmd_i,
  output ckvt_pkg::dp_status_t          status_o,
  input  wire [ckvt_pkg::OFFSET_W-1:0]  key_offset_i,
  input  wire [ckvt_pkg::KIND_W-1:0]    kind_i,
  input  wire [ckvt_pkg::DATA_W-1:0]    key_i,
  input  wire [ckvt_pkg::DATA_W-1:0]    value_i,
  input  wire [ckvt_pkg::PICK_W-1:0]    pick_i,
  output logic [ckvt_pkg::STATUS_W-1:0] res_status_o,
  output logic [ckvt_pkg::DATA_W-1:0]   res_found_o,
  output logic [ckvt_pkg::SLOT_W-1:0]   res_slot_o
);
  import ckvt_pkg::*;

  typedef struct packed {
    logic              live;
    logic [DATA_W-1:0] key;
  } key_word_t;

  typedef struct packed {
    logic              taken;
    logic [SPAN_W-1:0] off;
  } hole_word_t;

  // Latched item.
  kind_e             kind_q;
  logic [DATA_W-1:0] key_q, val_q;
  logic [1:0]        pick_q;
  logic [CL_W-1:0]   cl_q;
  logic [FILL_W-1:0] fill_q [4];
  logic [IDX_W-1:0]  idx_q;
  logic              pv_q;
  logic [IDX_W-1:0]  pidx_q;
  logic [SLOT_W-1:0] slot_q;

  // Memories. A slot at or beyond its chunk's fill count was never written
  // and counts as not live, so the live bit needs no clearing.
  key_word_t         key_mem [2**SLOT_W];
  logic [DATA_W-1:0] val_mem [2**SLOT_W];
  logic [FILL_W-1:0] fill_mem [2**(CL_W+2)];
  hole_word_t        hole_mem [2**(CL_W+HOLE_W)];
  logic [2**(CL_W+2)-1:0] fill_vld_q;
  logic [HCNT_W-1:0] hole_cnt_q [2**CL_W];

  key_word_t         key_rd_q;
  logic [DATA_W-1:0] val_rd_q;
  logic [FILL_W-1:0] fill_rd_q;
  logic              fill_rv_q;
  hole_word_t        hole_rd_q;

  // Range check of key plus offset.
  logic signed [DATA_W:0] sum;
  logic [DATA_W:0]        cl_wide;
  logic                   out_range;
  assign sum       = $signed({key_q[DATA_W-1], key_q}) + $signed({1'b0, key_offset_i});
  assign cl_wide   = {1'b0, sum[DATA_W-1:0]} >> SPAN_W;
  assign out_range = sum[DATA_W] || (cl_wide >= (DATA_W+1)'(NUM_CLUSTERS));

  // Scan match on the word read in the previous cycle.
  logic [SPAN_W-1:0]  poff;
  logic [1:0]         pchunk;
  logic               scan_hit, scan_miss;
  assign poff      = pidx_q[SPAN_W-1:0];
  assign pchunk    = poff[SPAN_W-1 -: 2];
  assign scan_hit  = pv_q && key_rd_q.live && (key_rd_q.key == key_q) &&
                     (FILL_W'(poff[CHUNK_W-1:0]) < fill_q[pchunk]);
  assign scan_miss = pv_q && !scan_hit && (poff == {SPAN_W{1'b1}});

  // Hole log scan.
  logic [HCNT_W-1:0] cnt;
  logic              hole_hit, hole_miss;
  assign cnt       = hole_cnt_q[cl_q];
  assign hole_hit  = pv_q && !hole_rd_q.taken && (hole_rd_q.off[SPAN_W-1 -: 2] == pick_q);
  assign hole_miss = !hole_hit && (idx_q >= IDX_W'(cnt));

  // Chunk choice for an append: first non-full chunk from pick_q on.
  logic [1:0] app_chunk;
  logic       app_ok;
  always_comb begin
    logic [1:0] c;
    app_chunk = pick_q;
    app_ok    = 1'b0;
    for (int j = 3; j >= 0; j--) begin
      c = pick_q + 2'(j);
      if (fill_q[c] < FILL_W'(CHUNK_SLOTS)) begin
        app_chunk = c;
        app_ok    = 1'b1;
      end
    end
  end

  logic [SLOT_W-1:0] app_slot;
  assign app_slot = {cl_q, app_chunk, fill_q[app_chunk][CHUNK_W-1:0]};

  assign status_o.out_range = out_range;
  assign status_o.fill_done = (idx_q == IDX_W'(4));
  assign status_o.scan_hit  = scan_hit;
  assign status_o.scan_miss = scan_miss;
  assign status_o.hole_hit  = hole_hit;
  assign status_o.hole_miss = hole_miss;
  assign status_o.kind      = kind_q;

  // Memory port controls.
  logic                      key_we, val_we, fill_we, hole_we;
  logic [SLOT_W-1:0]         key_waddr, key_raddr, val_waddr, val_raddr;
  key_word_t                 key_wdata;
  logic [DATA_W-1:0]         val_wdata;
  logic [CL_W+1:0]           fill_addr;
  logic [FILL_W-1:0]         fill_wdata;
  logic [CL_W+HOLE_W-1:0]    hole_waddr, hole_raddr;
  hole_word_t                hole_wdata;

  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    fill_we    = 1'b0;
    hole_we    = 1'b0;
    key_waddr  = slot_q;
    key_raddr  = {cl_q, idx_q[SPAN_W-1:0]};
    val_waddr  = slot_q;
    val_raddr  = slot_q;
    key_wdata  = '{live: 1'b1, key: key_q};
    val_wdata  = val_q;
    fill_addr  = {cl_q, idx_q[1:0]};
    fill_wdata = fill_q[app_chunk] + FILL_W'(1);
    hole_waddr = {cl_q, pidx_q[HOLE_W-1:0]};
    hole_raddr = {cl_q, idx_q[HOLE_W-1:0]};
    hole_wdata = '{taken: 1'b1, off: hole_rd_q.off};
    case (cmd_i.op)
      OP_HIT: begin
        if (kind_q == KIND_DELETE) begin
          key_we     = 1'b1;
          key_wdata  = '{live: 1'b0, key: key_q};
          hole_we    = (cnt < HCNT_W'(HOLE_SLOTS));
          hole_waddr = {cl_q, cnt[HOLE_W-1:0]};
          hole_wdata = '{taken: 1'b0, off: slot_q[SPAN_W-1:0]};
        end else if (kind_q == KIND_UPDATE) begin
          val_we = 1'b1;
        end
      end
      OP_HOLE: begin
        hole_we = hole_hit;
      end
      OP_WRITE: begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
      OP_APPEND: begin
        key_we    = app_ok;
        val_we    = app_ok;
        fill_we   = app_ok;
        key_waddr = app_slot;
        val_waddr = app_slot;
        fill_addr = {cl_q, app_chunk};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    val_rd_q <= val_mem[val_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_addr] <= fill_wdata;
    end
    fill_rd_q <= fill_mem[fill_addr];
  end

  always_ff @(posedge clk_i) begin
    if (hole_we) begin
      hole_mem[hole_waddr] <= hole_wdata;
    end
    hole_rd_q <= hole_mem[hole_raddr];
  end

  // Per-entry valid bits for the fill counts, and the per-cluster hole counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
      fill_rv_q  <= 1'b0;
      for (int c = 0; c < 2**CL_W; c++) begin
        hole_cnt_q[c] <= '0;
      end
    end else begin
      fill_rv_q <= fill_vld_q[fill_addr];
      if (fill_we) begin
        fill_vld_q[fill_addr] <= 1'b1;
      end
      if (cmd_i.op == OP_HIT && kind_q == KIND_DELETE && cnt < HCNT_W'(HOLE_SLOTS)) begin
        hole_cnt_q[cl_q] <= cnt + HCNT_W'(1);
      end
    end
  end

  // Item registers, counters and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pv_q   <= 1'b0;
      pidx_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_CHECK: begin
          idx_q <= '0;
          pv_q  <= 1'b0;
        end
        OP_FILL: begin
          idx_q <= (idx_q == IDX_W'(4)) ? '0 : idx_q + IDX_W'(1);
        end
        OP_SCAN: begin
          if (scan_hit || scan_miss) begin
            idx_q <= '0;
            pv_q  <= 1'b0;
          end else begin
            pv_q   <= !idx_q[SPAN_W];
            pidx_q <= idx_q;
            if (!idx_q[SPAN_W]) begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        OP_HOLE: begin
          pv_q   <= (idx_q < IDX_W'(cnt)) && !hole_hit;
          pidx_q <= idx_q;
          if (idx_q < IDX_W'(cnt)) begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        default: begin
          pv_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        kind_q <= kind_e'(kind_i);
        key_q  <= key_i;
        val_q  <= value_i;
        pick_q <= pick_i;
      end
      OP_CHECK: begin
        cl_q         <= cl_wide[CL_W-1:0];
        res_status_o <= ST_RANGE;
        res_found_o  <= '0;
        res_slot_o   <= '0;
      end
      OP_FILL: begin
        if (idx_q != '0) begin
          fill_q[idx_q[1:0] - 2'd1] <= fill_rv_q ? fill_rd_q : '0;
        end
      end
      OP_SCAN: begin
        if (scan_hit) begin
          slot_q <= {cl_q, poff};
        end else if (scan_miss) begin
          res_status_o <= ST_NOT_FOUND;
        end
      end
      OP_HIT: begin
        res_status_o <= ST_DONE;
        res_slot_o   <= slot_q;
      end
      OP_FOUND: begin
        res_found_o <= val_rd_q;
      end
      OP_HOLE: begin
        if (hole_hit) begin
          slot_q <= {cl_q, hole_rd_q.off};
        end
      end
      OP_WRITE: begin
        res_status_o <= ST_DONE;
        res_slot_o   <= slot_q;
      end
      OP_APPEND: begin
        if (app_ok) begin
          fill_q[app_chunk] <= fill_wdata;
          res_status_o      <= ST_DONE;
          res_slot_o        <= app_slot;
        end else begin
          res_status_o <= ST_FULL;
          res_slot_o   <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/ckvt_ctrl.sv
// Controller of the clustered key-value table: sequences one operation
// through the datapath. Depends on ckvt_pkg.
`default_nettype none

module ckvt_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output ckvt_pkg::cmd_t       cmd_o,
  input  ckvt_pkg::dp_status_t status_i
);
  import ckvt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_FILL, S_SCAN, S_HIT, S_FOUND,
    S_HOLE, S_WRITE, S_APPEND, S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    case (state_q)
      S_IDLE:   cmd_o.op = (in_valid_i) ? OP_LATCH : OP_NONE;
      S_CHECK:  cmd_o.op = OP_CHECK;
      S_FILL:   cmd_o.op = OP_FILL;
      S_SCAN:   cmd_o.op = OP_SCAN;
      S_HIT:    cmd_o.op = OP_HIT;
      S_FOUND:  cmd_o.op = OP_FOUND;
      S_HOLE:   cmd_o.op = OP_HOLE;
      S_WRITE:  cmd_o.op = OP_WRITE;
      S_APPEND: cmd_o.op = OP_APPEND;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          state_q <= status_i.out_range ? S_OUT : S_FILL;
        end
        S_FILL: begin
          if (status_i.fill_done) begin
            state_q <= (status_i.kind == KIND_INSERT) ? S_HOLE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (status_i.scan_hit) begin
            state_q <= S_HIT;
          end else if (status_i.scan_miss) begin
            state_q <= (status_i.kind == KIND_UPDATE) ? S_HOLE : S_OUT;
          end
        end
        S_HIT: begin
          state_q <= (status_i.kind == KIND_SEARCH) ? S_FOUND : S_OUT;
        end
        S_FOUND: begin
          state_q <= S_OUT;
        end
        S_HOLE: begin
          if (status_i.hole_hit) begin
            state_q <= S_WRITE;
          end else if (status_i.hole_miss) begin
            state_q <= S_APPEND;
          end
        end
        S_WRITE:  state_q <= S_OUT;
        S_APPEND: state_q <= S_OUT;
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/clustered_key_value_table.sv
// Top level of the clustered key-value table: APB register, controller and
// datapath. Depends on ckvt_pkg, ckvt_req_if, ckvt_rsp_if, ckvt_ctrl, ckvt_dpath.
//
//   channel  direction  word
//   req      in         kind, key, value, chunk_pick
//   rsp      out        status, found_value, slot_index
//   apb      in/out     key_offset register at byte address 0
//
// One word is taken at a time; its result word is presented before the next
// request is taken. A word passes the range check, the load of the cluster's
// four fill counts, the cluster scan (one key memory read per cycle) for all
// kinds but inserts, the hole log scan for inserts and for updates that miss,
// and the finishing steps; a key out of range goes from the check to the result.
// Reset clears the fill count valid bits and the hole counts at once, so no clearing pass is needed.
// A stalled result holds the block in its output state.
`default_nettype none

module clustered_key_value_table (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  ckvt_req_if.sink                       req,
  ckvt_rsp_if.source                     rsp,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [ckvt_pkg::PADDR_W-1:0]    paddr,
  input  wire [ckvt_pkg::PDATA_W-1:0]    pwdata,
  output logic [ckvt_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import ckvt_pkg::*;

  // The only register: offset added to a key before picking the cluster.
  logic [OFFSET_W-1:0] key_offset_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KEY_OFFSET) ? PDATA_W'(key_offset_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_offset_q <= OFFSET_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_KEY_OFFSET) begin
      key_offset_q <= pwdata[OFFSET_W-1:0];
    end
  end

  cmd_t              cmd;
  dp_status_t        dp_status;
  logic [SLOT_W-1:0] res_slot;

  ckvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd),
    .status_i    (dp_status)
  );

  ckvt_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .key_offset_i (key_offset_q),
    .kind_i       (req.kind),
    .key_i        (req.key),
    .value_i      (req.value),
    .pick_i       (req.chunk_pick),
    .res_status_o (rsp.status),
    .res_found_o  (rsp.found_value),
    .res_slot_o   (res_slot)
  );

  // Slot numbers are reported modulo the width of the result field.
  assign rsp.slot_index = SLOT_OUT_W'(res_slot);

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the clustered key-value table.
// Depends on ckvt_pkg, ckvt_req_if, ckvt_rsp_if and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
  import ckvt_pkg::*;

  localparam int TABLE_SLOTS = CLUSTER_SPAN * NUM_CLUSTERS;
  localparam int RANDOM_WORDS = 670;
  localparam int DRAIN_CYCLES = 400;

  // Hole log entry states.
  localparam logic [1:0] HOLE_NONE  = 2'd0;
  localparam logic [1:0] HOLE_VALID = 2'd1;
  localparam logic [1:0] HOLE_TAKEN = 2'd2;

  // One expected response word.
  typedef struct {
    status_e     status;
    logic [31:0] found_value;
    logic [11:0] slot_index;
  } rsp_word_t;

  // One row of the directed table. When has_fixed is set, the row's expected
  // status is typed in and compared with the predictor's as well.
  typedef struct {
    kind_e       kind;
    logic [31:0] key;
    logic [31:0] value;
    logic [1:0]  pick;
    bit          has_fixed;
    status_e     fixed_status;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  ckvt_req_if req ();
  ckvt_rsp_if rsp ();

  initial begin
    req.valid = 1'b0;
    req.kind = '0;
    req.key = '0;
    req.value = '0;
    req.chunk_pick = '0;
    rsp.ready = 1'b0;
  end

  clustered_key_value_table u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req.sink),
    .rsp     (rsp.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The predictor's private copy of the table state.
  logic [31:0] tbl_keys[TABLE_SLOTS];
  logic [31:0] tbl_vals[TABLE_SLOTS];
  bit          tbl_live[TABLE_SLOTS];
  int unsigned tbl_fill[4*NUM_CLUSTERS];
  logic [1:0]  hole_st[NUM_CLUSTERS*HOLE_SLOTS];
  int unsigned hole_off[NUM_CLUSTERS*HOLE_SLOTS];
  int unsigned hole_cnt[NUM_CLUSTERS];
  logic [OFFSET_W-1:0] cur_offset;

  rsp_word_t pending_rsp[$];
  int  err_count = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  status_seen[4] = '{0, 0, 0, 0};
  bit  stim_done = 1'b0;
  bit  hold_off = 1'b0;

  // Lowest live slot of the cluster holding the key, or -1 on a miss.
  function automatic int lookup_slot(int unsigned cl, logic [31:0] key);
    for (int i = 0; i < CLUSTER_SPAN; i++) begin
      if (tbl_live[cl*CLUSTER_SPAN+i] && tbl_keys[cl*CLUSTER_SPAN+i] == key)
        return cl*CLUSTER_SPAN + i;
    end
    return -1;
  endfunction

  // Places a new entry: an untaken hole in the chosen chunk first, otherwise
  // an append to the first chunk with room. Returns -1 when the cluster is full.
  function automatic int place_entry(int unsigned cl, logic [1:0] pick,
                                     logic [31:0] key, logic [31:0] val);
    int s;
    logic [1:0] chunk;
    s = -1;
    for (int i = 0; i < hole_cnt[cl] && i < HOLE_SLOTS; i++) begin
      if (hole_st[cl*HOLE_SLOTS+i] == HOLE_VALID &&
          hole_off[cl*HOLE_SLOTS+i] / CHUNK_SLOTS == pick) begin
        hole_st[cl*HOLE_SLOTS+i] = HOLE_TAKEN;
        s = cl*CLUSTER_SPAN + hole_off[cl*HOLE_SLOTS+i];
        break;
      end
    end
    if (s < 0) begin
      chunk = pick;
      for (int i = 0; i < 4; i++) begin
        if (tbl_fill[cl*4+chunk] < CHUNK_SLOTS) begin
          s = cl*CLUSTER_SPAN + chunk*CHUNK_SLOTS + tbl_fill[cl*4+chunk];
          tbl_fill[cl*4+chunk]++;
          break;
        end
        chunk = chunk + 2'd1;
      end
      if (s < 0) return -1;
    end
    tbl_keys[s] = key;
    tbl_vals[s] = val;
    tbl_live[s] = 1'b1;
    return s;
  endfunction

  // Computes the response of one request word and updates the state copy.
  function automatic rsp_word_t predict_table_op(kind_e kind, logic [31:0] key,
                                                 logic [31:0] val, logic [1:0] pick);
    rsp_word_t r;
    longint sum;
    int unsigned cl;
    int s;
    r.status = ST_DONE;
    r.found_value = '0;
    r.slot_index = '0;
    sum = longint'($signed(key)) + longint'(cur_offset);
    if (sum < 0 || sum / CLUSTER_SPAN >= NUM_CLUSTERS) begin
      r.status = ST_RANGE;
      return r;
    end
    cl = int'(sum / CLUSTER_SPAN);
    case (kind)
      KIND_INSERT: begin
        s = place_entry(cl, pick, key, val);
        if (s < 0) r.status = ST_FULL;
        else r.slot_index = s[11:0];
      end
      KIND_DELETE: begin
        s = lookup_slot(cl, key);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          tbl_live[s] = 1'b0;
          if (hole_cnt[cl] < HOLE_SLOTS) begin
            hole_st[cl*HOLE_SLOTS+hole_cnt[cl]] = HOLE_VALID;
            hole_off[cl*HOLE_SLOTS+hole_cnt[cl]] = s - cl*CLUSTER_SPAN;
            hole_cnt[cl]++;
          end
          r.slot_index = s[11:0];
        end
      end
      KIND_SEARCH: begin
        s = lookup_slot(cl, key);
        if (s < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_value = tbl_vals[s];
          r.slot_index = s[11:0];
        end
      end
      default: begin
        s = lookup_slot(cl, key);
        if (s >= 0) begin
          tbl_vals[s] = val;
          r.slot_index = s[11:0];
        end else begin
          s = place_entry(cl, pick, key, val);
          if (s < 0) r.status = ST_FULL;
          else r.slot_index = s[11:0];
        end
      end
    endcase
    return r;
  endfunction

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every expected response has come back, then lets the
  // block settle before the register is touched.
  task automatic set_key_offset(logic [OFFSET_W-1:0] offs);
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    apb_write({REG_KEY_OFFSET, 2'b00}, PDATA_W'(offs));
    cur_offset = offs;
  endtask

  // Offers one request word after a random gap and waits for acceptance.
  // The expectation is queued at the edge where the word is taken. Valid
  // stays up after acceptance until the next call draws a gap, so a word
  // with no gap follows without a second drive in the same step.
  task automatic send_request(kind_e kind, logic [31:0] key, logic [31:0] val,
                              logic [1:0] pick);
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(17);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.kind <= kind;
    req.key <= key;
    req.value <= val;
    req.chunk_pick <= pick;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_rsp.push_back(predict_table_op(kind, key, val, pick));
    words_sent++;
  endtask

  // Random key: mostly keys that land in the table, from a small pool so
  // that searches and deletes hit, with full-range noise mixed in.
  function automatic logic [31:0] draw_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 32'($signed(int'($urandom_range(40)) * 97 - int'(cur_offset) + 300));
    if (r < 85) return 32'(int'($urandom_range(TABLE_SLOTS - 1)) - int'(cur_offset));
    return $urandom;
  endfunction

  // Response side: random stalls, plus one long hold-off driven from its
  // own process through hold_off.
  initial begin
    int stall;
    rsp_word_t exp_w;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(2) == 0 ? 0 : $urandom_range(17);
      if (stall != 0 || hold_off) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp.valid) @(posedge clk_i);
      if (pending_rsp.size() == 0) begin
        $error("response word with no request outstanding");
        err_count++;
      end else begin
        exp_w = pending_rsp.pop_front();
        words_checked++;
        status_seen[rsp.status]++;
        if (rsp.status !== exp_w.status) begin
          $error("status: expected %0d, got %0d", exp_w.status, rsp.status);
          err_count++;
        end
        if (rsp.found_value !== exp_w.found_value) begin
          $error("found_value: expected %h, got %h", exp_w.found_value,
                 rsp.found_value);
          err_count++;
        end
        if (rsp.slot_index !== exp_w.slot_index) begin
          $error("slot_index: expected %0d, got %0d", exp_w.slot_index,
                 rsp.slot_index);
          err_count++;
        end
      end
    end
  end

  // Long receiver hold-off counted in cycles of its own.
  initial begin
    @(posedge rst_ni);
    repeat (20000) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (6000) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Directed table: extremes of each field, every operation, and each named
  // special case (out of range, duplicate insert, update hit, hole reuse).
  dir_row_t dir_rows[] = '{
    '{KIND_SEARCH, 32'h0000_0000, 32'h0, 2'd0, 1, ST_NOT_FOUND},
    '{KIND_DELETE, 32'h0000_0005, 32'h0, 2'd0, 1, ST_NOT_FOUND},
    '{KIND_INSERT, 32'h8000_0000, 32'h1, 2'd0, 1, ST_RANGE},
    '{KIND_INSERT, 32'h7FFF_FFFF, 32'h1, 2'd3, 1, ST_RANGE},
    '{KIND_SEARCH, 32'hFFFF_F7FF, 32'h0, 2'd0, 1, ST_RANGE},
    '{KIND_INSERT, 32'hFFFF_F800, 32'h7FFF_FFFF, 2'd0, 1, ST_DONE},
    '{KIND_INSERT, 32'h0000_0A00, 32'h8000_0000, 2'd3, 0, ST_DONE},
    '{KIND_INSERT, 32'h0000_07FF, 32'hFFFF_FFFF, 2'd2, 0, ST_DONE},
    '{KIND_INSERT, 32'h0000_0800, 32'h1, 2'd1, 1, ST_RANGE},
    '{KIND_INSERT, 32'h0000_0010, 32'h1111_1111, 2'd1, 0, ST_DONE},
    '{KIND_INSERT, 32'h0000_0010, 32'h2222_2222, 2'd2, 0, ST_DONE},
    '{KIND_SEARCH, 32'h0000_0010, 32'h0, 2'd0, 0, ST_DONE},
    '{KIND_UPDATE, 32'h0000_0010, 32'h3333_3333, 2'd0, 0, ST_DONE},
    '{KIND_SEARCH, 32'h0000_0010, 32'h0, 2'd0, 0, ST_DONE},
    '{KIND_DELETE, 32'h0000_0010, 32'h0, 2'd0, 0, ST_DONE},
    '{KIND_SEARCH, 32'h0000_0010, 32'h0, 2'd0, 0, ST_DONE},
    '{KIND_INSERT, 32'h0000_0020, 32'h4444_4444, 2'd1, 0, ST_DONE},
    '{KIND_UPDATE, 32'h0000_0030, 32'h5555_5555, 2'd1, 0, ST_DONE},
    '{KIND_DELETE, 32'h0000_0010, 32'h0, 2'd0, 0, ST_DONE},
    '{KIND_DELETE, 32'h0000_0010, 32'h0, 2'd0, 1, ST_NOT_FOUND},
    '{KIND_SEARCH, 32'h0000_0A00, 32'h0, 2'd0, 0, ST_DONE}
  };

  initial begin
    rsp_word_t fixed_w;
    kind_e k;
    logic [31:0] fill_key;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_keys[i] = '0;
      tbl_vals[i] = '0;
      tbl_live[i] = 1'b0;
    end
    foreach (tbl_fill[i]) tbl_fill[i] = 0;
    foreach (hole_st[i]) begin
      hole_st[i] = HOLE_NONE;
      hole_off[i] = 0;
    end
    foreach (hole_cnt[i]) hole_cnt[i] = 0;
    cur_offset = OFFSET_RESET;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset offset.
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].value,
                   dir_rows[i].pick);
      // The word just taken is the newest expectation in the queue.
      if (dir_rows[i].has_fixed) begin
        fixed_w = pending_rsp[$];
        if (fixed_w.status != dir_rows[i].fixed_status) begin
          $error("directed row %0d: status table %0d, predictor %0d", i,
                 dir_rows[i].fixed_status, fixed_w.status);
          err_count++;
        end
      end
    end

    // Fill one cluster to the top so that the cluster-full case is reached.
    // Offset 0 puts keys 0..255 in cluster 0.
    set_key_offset('0);
    for (int i = 0; i < 4*CHUNK_SLOTS + 2; i++) begin
      fill_key = 32'($urandom_range(255));
      send_request(KIND_INSERT, fill_key, $urandom, 2'($urandom_range(3)));
    end

    // Random part over several offsets, the extremes among them.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_key_offset(OFFSET_W'(2048));
        1: set_key_offset({OFFSET_W{1'b1}});
        2: set_key_offset(OFFSET_W'($urandom_range(4095)));
        3: set_key_offset('0);
        default: set_key_offset(OFFSET_W'($urandom));
      endcase
      for (int n = 0; n < RANDOM_WORDS / 5; n++) begin
        k = kind_e'($urandom_range(3));
        send_request(k, draw_key(), $urandom, 2'($urandom_range(3)));
      end
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Final check: nothing outstanding, then a settling period.
  initial begin
    wait (stim_done);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d of %0d words: %0d done, %0d not found, %0d out of range.",
             words_checked, words_sent, status_seen[0], status_seen[1], status_seen[2]);
    $display("Cluster-full responses: %0d, over five key offsets.", status_seen[3]);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: a bound many times over what about 950 words and the stalls need at worst.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
